FILE: src/sni_pkg.sv
// Shared types, constants and helper functions for the streaming numeric integrator.
package sni_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_METHOD  = 2'd0;
  localparam logic [1:0] REG_UNIFORM = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

  // Method code that selects Simpson weighting; every other code runs trapezoid
  localparam logic [1:0] METHOD_SIMPSON = 2'd1;

  // Reset values of the configuration registers
  localparam logic [1:0]  METHOD_RESET  = 2'd0;
  localparam logic        UNIFORM_RESET = 1'b1;
  localparam logic [31:0] SPACING_RESET = 32'h0001_0000;

  // Datapath widths
  localparam int SAMPLE_W = 32;               // Q16.16 samples
  localparam int OP_W     = SAMPLE_W + 3;     // signed operand before magnitude
  localparam int MAG_W    = OP_W - 1;         // operand magnitude
  localparam int PROD_W   = 2 * MAG_W;        // full magnitude product
  localparam int HALF_W   = PROD_W - 1;       // product after the rounded halving
  localparam int DIGIT_W  = 8;                // bits resolved per divide stage
  localparam int DIV_STAGES = (HALF_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W    = DIV_STAGES * DIGIT_W;
  localparam int ACC_W    = 64;               // Q32.32 accumulator
  localparam int CNT_W    = 32;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_FEW    = 2'd1,
    ST_EVEN_COUNT = 2'd2
  } status_t;

  // Per-sample control carried down the pipeline
  typedef struct packed {
    logic    add;     // sample closes an interval or a Simpson pair
    logic    neg;     // contribution is negative
    logic    div6;    // Simpson scaling, else divide by two
    logic    last;    // sample ends the run
    status_t status;  // run status, meaningful with last
  } sni_tag_t;

  // Long division of one byte by three: {remainder, quotient byte}
  function automatic logic [DIGIT_W+1:0] div3_step(input logic [1:0] rem_in,
                                                   input logic [DIGIT_W-1:0] digit);
    logic [1:0]         rem;
    logic [2:0]         cur;
    logic [DIGIT_W-1:0] quot;
    rem  = rem_in;
    quot = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      cur = {rem, digit[b]};
      if (cur >= 3'd3) begin
        quot[b] = 1'b1;
        cur     = cur - 3'd3;
      end
      rem = cur[1:0];
    end
    return {rem, quot};
  endfunction

  // Signed add clamped to the accumulator range
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] sum;
    sum = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && sum[ACC_W-1] != a[ACC_W-1]) begin
      sum = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return sum;
  endfunction

endpackage

FILE: src/streaming_numeric_integrator.sv
// Top level of the streaming numeric integrator.
// Takes one Q16.16 sample (f_value, x_value, last) per clock and integrates each run by
// trapezoid or Simpson weighting into a saturating Q32.32 accumulator; on the sample marked
// last it delivers one beat with the integral and a status. While input ready is high,
// samples stream in at one per cycle: the accumulator add is the only loop and takes one
// contribution per cycle, while the operand, multiply, rounding, nine-stage divide by three
// and saturation steps are pipelined ahead of it. Input ready drops only when a finished
// result is still waiting at the output and the next run's result has reached the
// accumulator. Configuration is to be written only while no run is in flight.
module streaming_numeric_integrator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            f_value,
  input  logic signed [31:0]            x_value,
  input  logic                          last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [63:0]            integral,
  output logic [1:0]                    status
);

  localparam int OP_W   = sni_pkg::OP_W;
  localparam int MAG_W  = sni_pkg::MAG_W;
  localparam int PROD_W = sni_pkg::PROD_W;
  localparam int HALF_W = sni_pkg::HALF_W;
  localparam int DIV_W  = sni_pkg::DIV_W;
  localparam int ACC_W  = sni_pkg::ACC_W;
  localparam int CNT_W  = sni_pkg::CNT_W;

  // configuration registers
  logic [1:0]  method;
  logic        uniform_spacing;
  logic [31:0] spacing;

  // run history
  logic signed [31:0] prev_f_near, prev_f_far, prev_x_near, prev_x_far;
  logic [CNT_W-1:0]   sample_count;

  // pipeline
  logic                  advance;
  logic                  s1_vld, s2_vld, s3_vld, c_vld;
  sni_pkg::sni_tag_t     s1_tag, s2_tag, s3_tag, c_tag, div_tag, in_tag;
  logic [MAG_W-1:0]      s1_mag_a, s1_mag_b;
  logic [PROD_W-1:0]     s2_prod, rounded;
  logic [HALF_W-1:0]     s3_half;
  logic                  div_vld;
  logic [DIV_W-1:0]      div_quot;
  logic                  over;
  logic [ACC_W-1:0]      contrib, c_contrib;
  logic [ACC_W-1:0]      acc, acc_sum;

  // operand build
  logic                  simpson;
  logic signed [OP_W-1:0] f_ext, fn_ext, ff_ext;
  logic signed [OP_W-1:0] trap_a, trap_b, simp_a, simp_b, op_a, op_b;
  logic [OP_W-1:0]        abs_a, abs_b;

  assign advance  = !(c_vld && c_tag.last && out_valid && !out_ready);
  assign in_ready = advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      method          <= sni_pkg::METHOD_RESET;
      uniform_spacing <= sni_pkg::UNIFORM_RESET;
      spacing         <= sni_pkg::SPACING_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        sni_pkg::REG_METHOD:  method          <= cfg_data[1:0];
        sni_pkg::REG_UNIFORM: uniform_spacing <= cfg_data[0];
        sni_pkg::REG_SPACING: spacing         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Form the two signed factors of this sample's contribution
  always_comb begin
    simpson = (method == sni_pkg::METHOD_SIMPSON);
    f_ext   = OP_W'(f_value);
    fn_ext  = OP_W'(prev_f_near);
    ff_ext  = OP_W'(prev_f_far);
    trap_a  = f_ext + fn_ext;
    trap_b  = uniform_spacing ? OP_W'({1'b0, spacing})
                              : OP_W'(x_value) - OP_W'(prev_x_near);
    simp_a  = uniform_spacing ? OP_W'({1'b0, spacing, 1'b0})
                              : OP_W'(x_value) - OP_W'(prev_x_far);
    simp_b  = ff_ext + (fn_ext <<< 2) + f_ext;
    op_a    = simpson ? simp_a : trap_a;
    op_b    = simpson ? simp_b : trap_b;
    abs_a   = op_a[OP_W-1] ? -op_a : op_a;
    abs_b   = op_b[OP_W-1] ? -op_b : op_b;

    in_tag.neg  = op_a[OP_W-1] ^ op_b[OP_W-1];
    in_tag.div6 = simpson;
    in_tag.last = last;
    if (simpson) begin
      in_tag.add = (sample_count >= CNT_W'(2)) && !sample_count[0];
      if (sample_count < CNT_W'(2)) begin
        in_tag.status = sni_pkg::ST_TOO_FEW;
      end else if (sample_count[0]) begin
        in_tag.status = sni_pkg::ST_EVEN_COUNT;
      end else begin
        in_tag.status = sni_pkg::ST_OK;
      end
    end else begin
      in_tag.add    = (sample_count != '0);
      in_tag.status = (sample_count == '0) ? sni_pkg::ST_TOO_FEW : sni_pkg::ST_OK;
    end
  end

  // Shift sample history; clear it when the run ends
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_f_near  <= '0;
      prev_f_far   <= '0;
      prev_x_near  <= '0;
      prev_x_far   <= '0;
      sample_count <= '0;
    end else if (in_valid && in_ready) begin
      if (last) begin
        prev_f_near  <= '0;
        prev_f_far   <= '0;
        prev_x_near  <= '0;
        prev_x_far   <= '0;
        sample_count <= '0;
      end else begin
        prev_f_near <= f_value;
        prev_f_far  <= prev_f_near;
        prev_x_near <= x_value;
        prev_x_far  <= prev_x_near;
        if (sample_count != '1) begin
          sample_count <= sample_count + CNT_W'(1);
        end
      end
    end
  end

  // Advance valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      c_vld  <= 1'b0;
    end else if (advance) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      c_vld  <= div_vld;
    end
  end

  // Register magnitudes, multiply, then round and halve
  assign rounded = s2_prod + (s2_tag.div6 ? PROD_W'(3) : PROD_W'(1));

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mag_a <= abs_a[MAG_W-1:0];
      s1_mag_b <= abs_b[MAG_W-1:0];
      s1_tag   <= in_tag;
      s2_prod  <= PROD_W'(s1_mag_a) * PROD_W'(s1_mag_b);
      s2_tag   <= s1_tag;
      s3_half  <= rounded[PROD_W-1:1];
      s3_tag   <= s2_tag;
    end
  end

  sni_div3_pipe u_div3 (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_vld   (s3_vld),
    .in_word  (s3_half),
    .in_tag   (s3_tag),
    .out_vld  (div_vld),
    .out_quot (div_quot),
    .out_tag  (div_tag)
  );

  // Apply sign and clamp the quotient to the accumulator range
  always_comb begin
    over = |div_quot[DIV_W-1:ACC_W-1];
    if (!div_tag.add) begin
      contrib = '0;
    end else if (div_tag.neg) begin
      contrib = over ? sni_pkg::ACC_MIN : -div_quot[ACC_W-1:0];
    end else begin
      contrib = over ? sni_pkg::ACC_MAX : div_quot[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_contrib <= contrib;
      c_tag     <= div_tag;
    end
  end

  assign acc_sum = sni_pkg::sat_add(acc, c_contrib);

  // Accumulate; drop the total into the result register at the end of a run
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance && c_vld) begin
        acc <= c_tag.last ? '0 : acc_sum;
      end
      if (advance && c_vld && c_tag.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && c_vld && c_tag.last) begin
      integral <= (c_tag.status == sni_pkg::ST_OK) ? acc_sum : '0;
      status   <= c_tag.status;
    end
  end

  // Checks
  a_stall_only_on_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && c_vld && c_tag.last))
    else $error("input stalled without a pending result");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && c_vld && c_tag.last) |=> (acc == '0))
    else $error("accumulator not cleared after run end");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != sni_pkg::ST_OK) |-> (integral == '0))
    else $error("flagged result carries a nonzero integral");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == sni_pkg::ST_OK || status == sni_pkg::ST_TOO_FEW ||
                   status == sni_pkg::ST_EVEN_COUNT))
    else $error("undefined status code");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> (sample_count != '0))
    else $error("sample count did not advance");

endmodule

FILE: src/sni_div3_pipe.sv
// Divide-by-three pipe for halved Simpson products, one byte per stage, with tag passthrough.
module sni_div3_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       in_vld,
  input  logic [sni_pkg::HALF_W-1:0] in_word,
  input  sni_pkg::sni_tag_t          in_tag,
  output logic                       out_vld,
  output logic [sni_pkg::DIV_W-1:0]  out_quot,
  output sni_pkg::sni_tag_t          out_tag
);

  localparam int NS = sni_pkg::DIV_STAGES;
  localparam int DW = sni_pkg::DIGIT_W;
  localparam int WW = sni_pkg::DIV_W;

  logic [WW-1:0]     word [NS+1];
  logic [1:0]        rem  [NS+1];
  sni_pkg::sni_tag_t tag  [NS+1];
  logic [NS:0]       vld;

  // Stage zero: zero-extend the dividend
  assign word[0] = {{(WW - sni_pkg::HALF_W){1'b0}}, in_word};
  assign rem[0]  = 2'd0;
  assign tag[0]  = in_tag;
  assign vld[0]  = in_vld;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW+1:0]     step;
    logic [WW-1:0]     word_next;
    logic [WW-1:0]     stage_word;
    logic [1:0]        stage_rem;
    sni_pkg::sni_tag_t stage_tag;
    logic              stage_vld;

    assign step = sni_pkg::div3_step(rem[k], word[k][WW-1-DW*k -: DW]);

    // Replace this stage's byte by its quotient for Simpson items
    always_comb begin
      word_next = word[k];
      if (tag[k].div6) begin
        word_next[WW-1-DW*k -: DW] = step[DW-1:0];
      end
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld <= 1'b0;
      end else if (advance) begin
        stage_vld <= vld[k];
      end
    end

    // Advance the word, remainder and tag
    always_ff @(posedge clk) begin
      if (advance) begin
        stage_word <= word_next;
        stage_tag  <= tag[k];
        stage_rem  <= step[DW+1:DW];
      end
    end

    assign word[k+1] = stage_word;
    assign rem[k+1]  = stage_rem;
    assign tag[k+1]  = stage_tag;
    assign vld[k+1]  = stage_vld;
  end

  assign out_vld  = vld[NS];
  assign out_quot = word[NS];
  assign out_tag  = tag[NS];

endmodule

FILE: tb/integral_checker.sv
// Checker for the streaming numeric integrator: watches all ports, predicts each run's integral.
`timescale 1ns / 100ps

module integral_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] f_value,
  input  logic signed [31:0] x_value,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [63:0] integral,
  input  logic [1:0]         status,
  output int                 mismatches,
  output int                 outstanding
);
  import sni_pkg::*;

  typedef struct {
    logic signed [63:0] area;
    status_t            code;
  } run_result_t;

  // Results of finished runs, oldest first
  run_result_t awaited_runs[$];

  // Shadow of the configuration registers
  logic [1:0]  method_q;
  logic        uniform_q;
  logic [31:0] spacing_q;

  // Shadow of the run state
  logic signed [31:0] f_near, f_far, x_near, x_far;
  logic [31:0]        run_len;
  logic signed [63:0] area_sum;

  // Product a*b divided by the divisor, rounded half away from zero, clamped to 64 bits
  function automatic logic signed [63:0] weighted_term(input logic signed [63:0] a,
                                                       input logic signed [63:0] b,
                                                       input logic [2:0]         divisor);
    logic [63:0]  mag_a, mag_b;
    logic [127:0] prod, quo;
    mag_a = a[63] ? -a : a;
    mag_b = b[63] ? -b : b;
    prod  = {64'd0, mag_a} * {64'd0, mag_b};
    quo   = (prod + 128'(divisor >> 1)) / 128'(divisor);
    if (a[63] != b[63]) begin
      if (quo >= 128'h8000_0000_0000_0000) return ACC_MIN;
      return -quo[63:0];
    end
    if (quo > 128'h7FFF_FFFF_FFFF_FFFF) return ACC_MAX;
    return quo[63:0];
  endfunction

  // Signed add that sticks at the 64-bit bounds
  function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? ACC_MIN : ACC_MAX;
    return s[63:0];
  endfunction

  task automatic clear_run();
    f_near   = '0;
    f_far    = '0;
    x_near   = '0;
    x_far    = '0;
    run_len  = '0;
    area_sum = '0;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] integral check: %s", $time, what);
    mismatches++;
  endtask

  // Fold one accepted sample into the run; queue the result when it ends the run
  task automatic absorb_sample(input logic signed [31:0] f, input logic signed [31:0] x,
                               input logic ends_run);
    logic [31:0]        idx;
    logic               pair_rule;
    logic signed [63:0] width, weight_sum;
    logic [32:0]        n;
    status_t            code;
    run_result_t        res;
    idx       = run_len;
    pair_rule = (method_q == METHOD_SIMPSON);
    if (pair_rule) begin
      // Simpson: close a pair of intervals on every odd sample past the first pair
      if (idx >= 2 && !idx[0]) begin
        if (uniform_q) begin
          width = {31'd0, spacing_q, 1'b0};
        end else begin
          width = 64'(x) - 64'(x_far);
        end
        weight_sum = 64'(f_far) + 4 * 64'(f_near) + 64'(f);
        area_sum   = clamp_sum(area_sum, weighted_term(width, weight_sum, 3'd6));
      end
    end else if (idx >= 1) begin
      // trapezoid, also for midpoint and the spare code
      if (uniform_q) begin
        width = {32'd0, spacing_q};
      end else begin
        width = 64'(x) - 64'(x_near);
      end
      weight_sum = 64'(f) + 64'(f_near);
      area_sum   = clamp_sum(area_sum, weighted_term(weight_sum, width, 3'd2));
    end
    f_far  = f_near;
    f_near = f;
    x_far  = x_near;
    x_near = x;
    if (run_len != '1) run_len++;
    if (ends_run) begin
      n    = {1'b0, idx} + 33'd1;
      code = ST_OK;
      if (pair_rule) begin
        if (n < 3) code = ST_TOO_FEW;
        else if (!n[0]) code = ST_EVEN_COUNT;
      end else if (n < 2) begin
        code = ST_TOO_FEW;
      end
      res.code = code;
      res.area = (code == ST_OK) ? area_sum : 64'sd0;
      awaited_runs.push_back(res);
      clear_run();
    end
  endtask

  always @(posedge clk) begin
    run_result_t due;
    if (rst) begin
      method_q  = METHOD_RESET;
      uniform_q = UNIFORM_RESET;
      spacing_q = SPACING_RESET;
      clear_run();
      awaited_runs.delete();
      mismatches = 0;
    end else begin
      // predict from the input beat
      if (in_valid && in_ready) absorb_sample(f_value, x_value, last);
      // track register writes; they apply from the next beat on
      if (cfg_write_en) begin
        case (cfg_index)
          REG_METHOD:  method_q  = cfg_data[1:0];
          REG_UNIFORM: uniform_q = cfg_data[0];
          REG_SPACING: spacing_q = cfg_data;
          default: ;
        endcase
      end
      // compare the result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected result integral=%h status=%0d",
                                    integral, status));
        end else begin
          due = awaited_runs.pop_front();
          if (integral !== due.area)
            report_mismatch($sformatf("integral %h, expected %h", integral, due.area));
          if (status !== due.code)
            report_mismatch($sformatf("status %0d, expected %0d", status, due.code));
        end
      end
    end
    outstanding <= awaited_runs.size();
  end

endmodule

FILE: tb/streaming_numeric_integrator_test.sv
// Top of the integrator testbench: clock, reset, sample and result traffic, verdict.
`timescale 1ns / 100ps

module streaming_numeric_integrator_test;
  import sni_pkg::*;

  // Method codes besides Simpson, and the unmapped register index
  localparam logic [1:0] METHOD_TRAPEZOID = 2'd0;
  localparam logic [1:0] METHOD_MIDPOINT  = 2'd2;
  localparam logic [1:0] METHOD_SPARE     = 2'd3;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

  // Ways of laying out x within a run
  localparam logic [1:0] X_ASCEND  = 2'd0;
  localparam logic [1:0] X_DESCEND = 2'd1;
  localparam logic [1:0] X_SCATTER = 2'd2;

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam int WATCHDOG_LIMIT      = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] f_value = '0;
  logic signed [31:0] x_value = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] integral;
  logic [1:0]         status;
  int                 mismatches;
  int                 outstanding;

  int unsigned beats_offered = 0;
  logic        steady_feed = 1'b0;
  int unsigned results_taken = 0;
  logic        steady_drain = 1'b0;
  int unsigned idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  streaming_numeric_integrator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .f_value      (f_value),
    .x_value      (x_value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .integral     (integral),
    .status       (status)
  );

  integral_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .f_value      (f_value),
    .x_value      (x_value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .integral     (integral),
    .status       (status),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Offer one sample beat after a random gap and hold it until taken
  task automatic send_sample(input logic signed [31:0] f, input logic signed [31:0] x,
                             input logic ends_run);
    int unsigned gap;
    if (beats_offered % 50 == 0) steady_feed = ($urandom_range(0, 2) == 0);
    beats_offered++;
    gap = steady_feed ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    f_value  <= f;
    x_value  <= x;
    last     <= ends_run;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let the pipeline drain
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write every register, with junk in the unused upper bits
  task automatic write_config(input logic [1:0] meth, input logic uni, input logic [31:0] sp);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_METHOD;
    cfg_data     <= ($urandom & ~32'h3) | meth;
    @(posedge clk);
    cfg_index <= REG_UNIFORM;
    cfg_data  <= ($urandom & ~32'h1) | uni;
    @(posedge clk);
    cfg_index <= REG_SPACING;
    cfg_data  <= sp;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Mostly small values, some full-range, some at the extremes
  function automatic logic signed [31:0] random_level();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2:    v = $urandom;
      default: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_run_length(input logic simpson);
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if (simpson && $urandom_range(0, 9) < 7) return 2 * $urandom_range(1, 7) + 1;
    return $urandom_range(1, 10);
  endfunction

  // Send one run with random levels and x laid out by style
  task automatic send_run(input int unsigned len, input logic [1:0] style);
    logic signed [31:0] xpos;
    logic [31:0]        step;
    xpos = $urandom;
    step = $urandom_range(1, 32'h0004_0000);
    for (int unsigned j = 0; j < len; j++) begin
      send_sample(random_level(), (style == X_SCATTER) ? 32'($urandom) : xpos, j == len - 1);
      if (style == X_DESCEND) xpos = xpos - step - $urandom_range(0, 255);
      else xpos = xpos + step + $urandom_range(0, 255);
    end
  endtask

  // Result side: random stalls, quiet stretches, and long hold-offs that back up the input
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_taken % 40 == 0) steady_drain = ($urandom_range(0, 2) == 0);
      if (results_taken == 15 || $urandom_range(0, 59) == 0) begin
        stall = $urandom_range(120, 200);
      end else begin
        stall = steady_drain ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  meth;
    logic        uni;
    logic [31:0] sp;
    int unsigned sent, len;
    logic [1:0]  style;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: a lone sample, then a run through the field extremes
    send_sample(32'sh7FFF_FFFF, 32'sh0000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh0000_0000, 32'sh8000_0000, 1'b1);

    // Simpson with runs of one to four samples: too short, ok, even count
    quiesce();
    write_config(METHOD_SIMPSON, 1'b1, SPACING_RESET);
    for (int n = 1; n <= 4; n++) begin
      for (int j = 0; j < n; j++) send_sample(ONE * (j + 1), ONE * j, j == n - 1);
    end

    // Midpoint on descending x
    quiesce();
    write_config(METHOD_MIDPOINT, 1'b0, SPACING_RESET);
    send_sample(ONE, 3 * ONE, 1'b0);
    send_sample(2 * ONE, ONE, 1'b0);
    send_sample(3 * ONE, -5 * ONE, 1'b1);

    // Spare method code at widest spacing: drive the sum into both bounds
    quiesce();
    write_config(METHOD_SPARE, 1'b1, 32'hFFFF_FFFF);
    for (int j = 0; j < 3; j++) send_sample(32'sh7FFF_FFFF, 32'sh0000_0000, j == 2);
    for (int j = 0; j < 3; j++) send_sample(32'sh8000_0000, 32'sh0000_0000, j == 2);

    // Random runs over a sweep of settings
    for (int k = 0; k < 10; k++) begin
      case (k % 4)
        0:       meth = METHOD_TRAPEZOID;
        1:       meth = METHOD_SIMPSON;
        2:       meth = METHOD_MIDPOINT;
        default: meth = METHOD_SPARE;
      endcase
      uni = (k >= 4);
      case (k % 5)
        0:       sp = '0;
        1:       sp = '1;
        2:       sp = SPACING_RESET;
        3:       sp = $urandom_range(1, 32'h0004_0000);
        default: sp = $urandom;
      endcase
      quiesce();
      write_config(meth, uni, sp);
      sent = 0;
      while (sent < 80) begin
        len = pick_run_length(meth == METHOD_SIMPSON);
        case ($urandom_range(0, 9))
          0, 1:    style = X_DESCEND;
          2:       style = X_SCATTER;
          default: style = X_ASCEND;
        endcase
        send_run(len, style);
        sent += len;
      end
    end

    quiesce();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
